// ===== rtl/core/mfb_pkg.sv =====
// Shared types and codes for the mono framebuffer draw engine.
package mfb_pkg;

	localparam int COORD_W = 11;   // clipped coordinate, holds 0..1024
	localparam int NUM_W   = 20;   // pixel bit number, screen up to 1024 x 1024
	localparam int BADDR_W = 17;   // store byte index

	// command codes on the input channel
	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_SET    = 3'd1;
	localparam logic [2:0] CMD_GET    = 3'd2;
	localparam logic [2:0] CMD_HLINE  = 3'd3;
	localparam logic [2:0] CMD_VLINE  = 3'd4;
	localparam logic [2:0] CMD_FILL   = 3'd5;
	localparam logic [2:0] CMD_INVERT = 3'd6;
	localparam logic [2:0] CMD_RDBYTE = 3'd7;

	// operation classes handed to the back end
	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_PAINT  = 3'd1;
	localparam logic [2:0] OP_INVERT = 3'd2;
	localparam logic [2:0] OP_PIXEL  = 3'd3;
	localparam logic [2:0] OP_BYTE   = 3'd4;

	typedef struct packed {
		logic [2:0]         op;
		logic               ink;
		logic               ok;      // region not empty / pixel on screen / byte in range
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] y1;
		logic [BADDR_W-1:0] addr;
		logic [2:0]         bsel;
	} item_t;

	typedef struct packed {
		logic init_busy;
		logic idle;
	} status_t;

endpackage

// ===== rtl/core/mfb_ram.sv =====
// Generic single-port RAM with registered read.
module mfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                          wdata,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

// ===== rtl/core/mfb_front.sv =====
// Front end: decode commands, clip regions and compute pixel addresses.
module mfb_front #(
	parameter int SCREEN_W = 400,
	parameter int SCREEN_H = 300
) (
	input  logic                [2:0]  command,
	input  logic signed         [11:0] pos_x,
	input  logic signed         [11:0] pos_y,
	input  logic                [10:0] span_w,
	input  logic                [10:0] span_h,
	input  logic                       ink_black,
	input  logic                [13:0] byte_addr,
	output mfb_pkg::item_t             item
);
	import mfb_pkg::*;

	localparam int STORE_BYTES = (SCREEN_W * SCREEN_H + 7) / 8;

	logic [10:0]        ws, hs;
	logic signed [12:0] xs, ys, xe, ye, x0s, x1s, y0s, y1s;
	logic signed [12:0] wc, hc;
	logic               on_scr;
	logic [NUM_W-1:0]   n;

	always_comb begin
		wc = 13'(SCREEN_W);
		hc = 13'(SCREEN_H);
		ws = (command == CMD_HLINE || command == CMD_FILL || command == CMD_INVERT)
			? span_w : 11'd1;
		hs = (command == CMD_VLINE || command == CMD_FILL || command == CMD_INVERT)
			? span_h : 11'd1;
		xs  = {pos_x[11], pos_x};
		ys  = {pos_y[11], pos_y};
		xe  = xs + $signed({2'b00, ws});
		ye  = ys + $signed({2'b00, hs});
		x0s = (xs < 0) ? 13'sd0 : xs;
		y0s = (ys < 0) ? 13'sd0 : ys;
		x1s = (xe > wc) ? wc : xe;
		y1s = (ye > hc) ? hc : ye;
		on_scr = (xs >= 0) && (xs < wc) && (ys >= 0) && (ys < hc);
		n = NUM_W'(ys[9:0]) * NUM_W'(SCREEN_W) + NUM_W'(xs[9:0]);

		item.ink  = ink_black;
		item.x0   = x0s[COORD_W-1:0];
		item.x1   = x1s[COORD_W-1:0];
		item.y0   = y0s[COORD_W-1:0];
		item.y1   = y1s[COORD_W-1:0];
		item.addr = n[NUM_W-1:3];
		item.bsel = n[2:0];
		item.ok   = (x1s > x0s) && (y1s > y0s);
		case (command)
			CMD_CLEAR: begin
				item.op = OP_CLEAR;
				item.ok = 1'b1;
			end
			CMD_GET: begin
				item.op = OP_PIXEL;
				item.ok = on_scr;
			end
			CMD_INVERT: item.op = OP_INVERT;
			CMD_RDBYTE: begin
				item.op   = OP_BYTE;
				item.addr = BADDR_W'(byte_addr);
				item.ok   = 32'(byte_addr) < STORE_BYTES;
			end
			default: item.op = OP_PAINT;
		endcase
	end
endmodule

// ===== rtl/core/mfb_queue.sv =====
// Two-entry command queue between front and back end.
module mfb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mfb_pkg::item_t wdata,
	input  logic           pop,
	output mfb_pkg::item_t rdata,
	output logic           empty,
	output logic           full,
	output logic [1:0]     level
);
	import mfb_pkg::*;

	item_t      ent_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign rdata = ent_q[rptr_q];
	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign level = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== rtl/core/mfb_back.sv =====
// Back end: sequencer that carries out commands on the pixel store.
module mfb_back #(
	parameter int SCREEN_W = 400,
	parameter int SCREEN_H = 300
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  mfb_pkg::item_t   q_item,
	output logic             q_pop,
	output mfb_pkg::status_t status,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             pixel_black,
	output logic             pixel_valid,
	output logic [7:0]       byte_value
);
	import mfb_pkg::*;

	localparam int STORE_BYTES = (SCREEN_W * SCREEN_H + 7) / 8;
	localparam int AW = STORE_BYTES > 1 ? $clog2(STORE_BYTES) : 1;

	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_SETUP = 4'd2;
	localparam logic [3:0] S_ROW   = 4'd3;
	localparam logic [3:0] S_RD    = 4'd4;
	localparam logic [3:0] S_WR    = 4'd5;
	localparam logic [3:0] S_CLR   = 4'd6;
	localparam logic [3:0] S_RDX   = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]         state_q;
	item_t              cur_q;
	logic [NUM_W-1:0]   base_q;
	logic [COORD_W-1:0] row_q;
	logic [BADDR_W-1:0] byte_q, last_q;
	logic [2:0]         lo_q, hi_q;
	logic               first_q;
	logic               out_valid_q, black_q, pvalid_q;
	logic [7:0]         bval_q;

	logic [NUM_W-1:0]   n0, n1;
	logic [7:0]         mask, wdata, rdata;
	logic               ram_we, ram_re, can_out;
	logic [AW-1:0]      ram_addr;

	assign can_out = !out_valid_q || !out_stall;
	assign q_pop   = (state_q == S_IDLE) && !q_empty;
	assign status.init_busy = (state_q == S_INIT);
	assign status.idle      = (state_q == S_IDLE);

	always_comb begin
		n0 = base_q + NUM_W'(cur_q.x0);
		n1 = base_q + NUM_W'(cur_q.x1) - NUM_W'(1);
		for (int k = 0; k < 8; k++) begin
			mask[7-k] = (!first_q || 3'(k) >= lo_q) && (byte_q != last_q || 3'(k) <= hi_q);
		end
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = byte_q[AW-1:0];
		wdata    = rdata & ~mask;
		case (state_q)
			S_INIT: begin
				ram_we = 1'b1;
				wdata  = 8'h00;
			end
			S_CLR: begin
				ram_we = 1'b1;
				wdata  = {8{cur_q.ink}};
			end
			S_RD: ram_re = 1'b1;
			S_RDX: begin
				ram_re   = 1'b1;
				ram_addr = cur_q.addr[AW-1:0];
			end
			S_WR: begin
				ram_we = 1'b1;
				if (cur_q.op == OP_INVERT) begin
					wdata = rdata ^ mask;
				end else if (cur_q.ink) begin
					wdata = rdata | mask;
				end
			end
			default: ;
		endcase
	end

	mfb_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: cur_q <= q_item;
			S_SETUP: begin
				base_q <= NUM_W'(cur_q.y0) * NUM_W'(SCREEN_W);
				row_q  <= cur_q.y0;
			end
			S_ROW: begin
				last_q  <= n1[NUM_W-1:3];
				lo_q    <= n0[2:0];
				hi_q    <= n1[2:0];
				first_q <= 1'b1;
			end
			S_WR: begin
				first_q <= 1'b0;
				if (byte_q == last_q) begin
					row_q  <= row_q + COORD_W'(1);
					base_q <= base_q + NUM_W'(SCREEN_W);
				end
			end
			default: ;
		endcase
		if (state_q == S_DONE && can_out) begin
			black_q  <= (cur_q.op == OP_PIXEL) && cur_q.ok && rdata[3'd7 - cur_q.bsel];
			pvalid_q <= (cur_q.op == OP_PIXEL) && cur_q.ok;
			bval_q   <= (cur_q.op == OP_BYTE && cur_q.ok) ? rdata : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			byte_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && can_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT, S_CLR: begin
					if (32'(byte_q) == STORE_BYTES - 1) begin
						state_q <= (state_q == S_INIT) ? S_IDLE : S_DONE;
					end else begin
						byte_q <= byte_q + BADDR_W'(1);
					end
				end
				S_IDLE: begin
					if (!q_empty) begin
						byte_q <= '0;
						case (q_item.op)
							OP_CLEAR:            state_q <= S_CLR;
							OP_PAINT, OP_INVERT: state_q <= q_item.ok ? S_SETUP : S_DONE;
							OP_PIXEL, OP_BYTE:   state_q <= q_item.ok ? S_RDX : S_DONE;
							default:             state_q <= S_DONE;
						endcase
					end
				end
				S_SETUP: state_q <= S_ROW;
				S_ROW: begin
					byte_q  <= n0[NUM_W-1:3];
					state_q <= S_RD;
				end
				S_RD:    state_q <= S_WR;
				S_WR: begin
					if (byte_q != last_q) begin
						byte_q  <= byte_q + BADDR_W'(1);
						state_q <= S_RD;
					end else if (row_q + COORD_W'(1) == cur_q.y1) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_ROW;
					end
				end
				S_RDX: state_q <= S_DONE;
				S_DONE: begin
					if (can_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_black = black_q;
	assign pixel_valid = pvalid_q;
	assign byte_value  = bval_q;
endmodule

// ===== rtl/core/mono_framebuffer_draw_engine.sv =====
// Top level: 1 bpp framebuffer draw engine, front end, queue and back end.
// Get pixel and byte read each read one store byte; set pixel is a
// 1 by 1 rectangle; lines and rectangles are worked row by row, and
// each store byte is a read-modify-write on the single-port store. Clear writes one
// byte a cycle. Commands run one at a time. After reset the store is swept to white,
// one byte a cycle; in_stall stays high until the sweep ends.
module mono_framebuffer_draw_engine #(
	parameter int SCREEN_W = 400,
	parameter int SCREEN_H = 300
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic        [2:0]  command,
	input  logic signed [11:0] pos_x,
	input  logic signed [11:0] pos_y,
	input  logic        [10:0] span_w,
	input  logic        [10:0] span_h,
	input  logic               ink_black,
	input  logic        [13:0] byte_addr,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               pixel_black,
	output logic               pixel_valid,
	output logic        [7:0]  byte_value
);
	import mfb_pkg::*;

	item_t      f_item, q_item;
	status_t    st;
	logic       q_empty, q_full, q_pop, push;
	logic [1:0] q_level;

	assign in_stall = q_full || st.init_busy;
	assign push     = in_valid && !in_stall;

	mfb_front #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_front (
		.command   (command),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.span_w    (span_w),
		.span_h    (span_h),
		.ink_black (ink_black),
		.byte_addr (byte_addr),
		.item      (f_item)
	);

	mfb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_item),
		.pop    (q_pop),
		.rdata  (q_item),
		.empty  (q_empty),
		.full   (q_full),
		.level  (q_level)
	);

	mfb_back #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.status      (st),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_black (pixel_black),
		.pixel_valid (pixel_valid),
		.byte_value  (byte_value)
	);

	a_init_stall: assert property (@(posedge clk) disable iff (!arst_n)
		st.init_busy |-> in_stall) else $error("transaction taken during store sweep");
	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		st.init_busy |-> !out_valid && q_empty) else $error("activity during store sweep");
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		q_level != 2'd3) else $error("queue overflow");
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_valid |-> byte_value == 8'h00) else $error("mixed result fields");
endmodule

// ===== test/mfb_checker.sv =====
// Checker for the mono framebuffer draw engine: predicts results and compares them.
module mfb_checker #(
	parameter int SCREEN_W = 400,
	parameter int SCREEN_H = 300
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic        [2:0]  command,
	input  logic signed [11:0] pos_x,
	input  logic signed [11:0] pos_y,
	input  logic        [10:0] span_w,
	input  logic        [10:0] span_h,
	input  logic               ink_black,
	input  logic        [13:0] byte_addr,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               pixel_black,
	input  logic               pixel_valid,
	input  logic        [7:0]  byte_value,
	output int                 fail_count,
	output int                 pending,
	output int                 accepted_cmds,
	output int                 accepted_results
);
	import mfb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBYTES = (SCREEN_W * SCREEN_H + 7) / 8;

	typedef struct {
		logic       black;
		logic       valid;
		logic [7:0] value;
	} answer_t;

	logic [7:0] shadow_fb [NBYTES];
	answer_t    answer_q [$];

	assign pending = answer_q.size();

	function automatic logic pixel_at(int x, int y);
		int n;
		n = y * SCREEN_W + x;
		return shadow_fb[n >> 3][7 - (n & 7)];
	endfunction

	function automatic void paint_pixel(int x, int y, logic ink);
		int n;
		if (x < 0 || x >= SCREEN_W || y < 0 || y >= SCREEN_H)
			return;
		n = y * SCREEN_W + x;
		shadow_fb[n >> 3][7 - (n & 7)] = ink;
	endfunction

	function automatic void draw_region(int x, int y, int w, int h, logic ink, bit flip);
		int x0, y0, x1, y1;
		x0 = x < 0 ? 0 : x;
		y0 = y < 0 ? 0 : y;
		x1 = x + w > SCREEN_W ? SCREEN_W : x + w;
		y1 = y + h > SCREEN_H ? SCREEN_H : y + h;
		for (int py = y0; py < y1; py++)
			for (int px = x0; px < x1; px++)
				paint_pixel(px, py, flip ? !pixel_at(px, py) : ink);
	endfunction

	function automatic answer_t apply_command(logic [2:0] cmd, int x, int y, int w, int h,
			logic ink, int addr);
		answer_t a;
		a = '{1'b0, 1'b0, 8'd0};
		case (cmd)
			CMD_CLEAR: begin
				foreach (shadow_fb[i])
					shadow_fb[i] = {8{ink}};
			end
			CMD_SET:    paint_pixel(x, y, ink);
			CMD_GET: begin
				if (x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H) begin
					a.valid = 1'b1;
					a.black = pixel_at(x, y);
				end
			end
			CMD_HLINE:  draw_region(x, y, w, 1, ink, 1'b0);
			CMD_VLINE:  draw_region(x, y, 1, h, ink, 1'b0);
			CMD_FILL:   draw_region(x, y, w, h, ink, 1'b0);
			CMD_INVERT: draw_region(x, y, w, h, 1'b0, 1'b1);
			CMD_RDBYTE: begin
				if (addr < NBYTES)
					a.value = shadow_fb[addr];
			end
			default: ;
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			foreach (shadow_fb[i])
				shadow_fb[i] = 8'd0;
			answer_q.delete();
			fail_count = 0;
			accepted_cmds = 0;
			accepted_results = 0;
		end else begin
			// check results before predicting, so a same-cycle command cannot race ahead
			if (out_valid && !out_stall) begin
				accepted_results++;
				if (answer_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result black=%0b valid=%0b byte=%02h",
							$realtime, pixel_black, pixel_valid, byte_value);
				end else begin
					want = answer_q.pop_front();
					if (want.black !== pixel_black || want.valid !== pixel_valid
							|| want.value !== byte_value) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: exp b/v/byte %0b/%0b/%02h got %0b/%0b/%02h",
								$realtime, want.black, want.valid, want.value,
								pixel_black, pixel_valid, byte_value);
					end
				end
			end
			if (in_valid && !in_stall) begin
				accepted_cmds++;
				answer_q.push_back(apply_command(command, int'(pos_x), int'(pos_y),
					int'(span_w), int'(span_h), ink_black, int'(byte_addr)));
			end
		end
	end

	final
		if (answer_q.size() != 0)
			$display("%0d results never arrived", answer_q.size());

endmodule

// ===== test/tb_top.sv =====
// Stimulus and verdict for the mono framebuffer draw engine test.
module tb_top;
	import mfb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = 400;
	localparam int SH = 300;
	localparam int NBYTES = (SW * SH + 7) / 8;
	localparam int WATCHDOG = 200000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic        [2:0]  command = CMD_CLEAR;
	logic signed [11:0] pos_x = '0;
	logic signed [11:0] pos_y = '0;
	logic        [10:0] span_w = '0;
	logic        [10:0] span_h = '0;
	logic               ink_black = 1'b0;
	logic        [13:0] byte_addr = '0;
	logic               out_valid;
	logic               out_stall = 1'b1;
	logic               pixel_black;
	logic               pixel_valid;
	logic        [7:0]  byte_value;

	int  fail_count, pending, accepted_cmds, accepted_results;
	bit  stim_done = 1'b0;
	bit  long_hold = 1'b0;
	int  idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	mono_framebuffer_draw_engine #(.SCREEN_W(SW), .SCREEN_H(SH)) uut (.*);

	mfb_checker #(.SCREEN_W(SW), .SCREEN_H(SH)) checker_i (.*);

	task automatic idle_bus();
		in_valid <= 1'b0;
		// random junk on the idle bus
		command   <= 3'($urandom);
		pos_x     <= 12'($urandom);
		byte_addr <= 14'($urandom);
	endtask

	task automatic send_cmd(logic [2:0] cmd, int x, int y, int w, int h, logic ink, int addr);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			idle_bus();
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		pos_x     <= 12'(x);
		pos_y     <= 12'(y);
		span_w    <= 11'(w);
		span_h    <= 11'(h);
		ink_black <= ink;
		byte_addr <= 14'(addr);
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random();
		logic [2:0] cmd;
		int x, y, w, h;
		int r;
		r = $urandom_range(0, 99);
		if (r < 2) cmd = CMD_CLEAR;
		else if (r < 14) cmd = CMD_SET;
		else if (r < 34) cmd = CMD_GET;
		else if (r < 44) cmd = CMD_HLINE;
		else if (r < 54) cmd = CMD_VLINE;
		else if (r < 64) cmd = CMD_FILL;
		else if (r < 74) cmd = CMD_INVERT;
		else cmd = CMD_RDBYTE;
		// mostly near the screen, sometimes anywhere in the field range
		if ($urandom_range(0, 9) == 0) begin
			x = $signed(12'($urandom));
			y = $signed(12'($urandom));
		end else begin
			x = $urandom_range(0, SW + 19) - 10;
			y = $urandom_range(0, SH + 19) - 10;
		end
		// keep areas small so each drawing is quick; rarely huge
		if ($urandom_range(0, 24) == 0) begin
			w = $urandom_range(0, 2047);
			h = $urandom_range(0, 2047);
		end else begin
			w = $urandom_range(0, 40);
			h = $urandom_range(0, 40);
		end
		send_cmd(cmd, x, y, w, h, $urandom_range(0, 1),
			$urandom_range(0, 7) == 0 ? $urandom_range(0, 16383)
				: $urandom_range(0, NBYTES - 1));
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
	endtask

	// receiver: random stall per result, one long hold when asked
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
				long_hold = 1'b0;
			end
			wait_n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
			if (wait_n != 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid && !long_hold);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		// reset sweep of the store may run long before the first transaction
		if (idle_cycles > WATCHDOG) begin
			$display("watchdog expired");
			$display("mono_framebuffer_draw_engine test failed");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every command, edges of the screen and the fields
		send_cmd(CMD_RDBYTE, 0, 0, 0, 0, 0, 0);
		send_cmd(CMD_RDBYTE, 0, 0, 0, 0, 0, 16383);
		send_cmd(CMD_SET, 0, 0, 0, 0, 1, 0);
		send_cmd(CMD_SET, SW - 1, SH - 1, 0, 0, 1, 0);
		send_cmd(CMD_SET, -1, 5, 0, 0, 1, 0);
		send_cmd(CMD_SET, SW, 5, 0, 0, 1, 0);
		send_cmd(CMD_GET, 0, 0, 0, 0, 0, 0);
		send_cmd(CMD_GET, SW - 1, SH - 1, 0, 0, 0, 0);
		send_cmd(CMD_GET, -2048, 2047, 0, 0, 0, 0);
		send_cmd(CMD_GET, 5, SH, 0, 0, 0, 0);
		send_cmd(CMD_HLINE, -5, 3, 20, 0, 1, 0);
		send_cmd(CMD_VLINE, 7, -3, 0, 12, 1, 0);
		send_cmd(CMD_FILL, 390, 290, 2047, 2047, 1, 0);
		send_cmd(CMD_FILL, 10, 10, 0, 5, 1, 0);
		send_cmd(CMD_FILL, 2047, -2048, 50, 50, 1, 0);
		send_cmd(CMD_INVERT, 3, 1, 13, 6, 0, 0);
		send_cmd(CMD_RDBYTE, 0, 0, 0, 0, 0, NBYTES - 1);
		send_cmd(CMD_RDBYTE, 0, 0, 0, 0, 0, NBYTES);
		send_cmd(CMD_CLEAR, 0, 0, 0, 0, 1, 0);
		send_cmd(CMD_RDBYTE, 0, 0, 0, 0, 0, NBYTES - 1);
		send_cmd(CMD_GET, 100, 100, 0, 0, 0, 0);
		send_cmd(CMD_INVERT, -2048, -2048, 2047, 2047, 0, 0);
		send_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		idle_bus();

		// sender pauses until everything is back
		drain();
		// long receiver hold while commands keep coming
		long_hold = 1'b1;
		for (int i = 0; i < 40; i++) begin
			send_cmd(i % 2 ? CMD_GET : CMD_SET, i, i, 0, 0, 1, 0);
		end
		for (int i = 0; i < 390; i++) begin
			send_random();
		end
		idle_bus();
		stim_done = 1'b1;
		drain();
		repeat (50) @(posedge clk);
		$display("%0d commands accepted, %0d results checked, all commands and clipping cases hit",
			accepted_cmds, accepted_results);
		if (fail_count == 0 && pending == 0)
			$display("mono_framebuffer_draw_engine test passed");
		else
			$display("mono_framebuffer_draw_engine test failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/mfb_pkg.sv
rtl/core/mfb_ram.sv
rtl/core/mfb_front.sv
rtl/core/mfb_queue.sv
rtl/core/mfb_back.sv
rtl/core/mono_framebuffer_draw_engine.sv
test/mfb_checker.sv
test/tb_top.sv
